### rtl/linear_probe_hash_table_assert.svh
// Assertion macros used by the hash table checker.
`ifndef LINEAR_PROBE_HASH_TABLE_ASSERT_SVH
`define LINEAR_PROBE_HASH_TABLE_ASSERT_SVH

// Condition that must hold at every clock edge outside reset.
`define LPHT_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Condition in one cycle implies a consequence in the next cycle.
`define LPHT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/lpht_pkg.sv
// Types and constants of the linear probing hash table.
package lpht_pkg;

  localparam int MAX_CAPACITY   = 1024;
  localparam int START_CAPACITY = 16;
  localparam int KEY_BYTES      = 8;
  localparam int VALUE_WIDTH    = 32;

  localparam int ADDR_W = $clog2(MAX_CAPACITY);
  localparam int CNT_W  = ADDR_W + 1;
  localparam int KEY_W  = 64;
  localparam int LEN_W  = 4;

  localparam logic [63:0] HASH_BASIS = 64'hCBF29CE484222325;
  localparam logic [63:0] HASH_MULT  = 64'h00000100000001B3;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_NULL = 2'd2,
    ST_FULL = 2'd3
  } lpht_status_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_START, S_HASH, S_PRD, S_PCHK, S_RESP,
    S_COPY_RD, S_COPY_WR, S_TMP_RD, S_TMP_CHK
  } lpht_state_t;

  typedef struct packed {
    logic                  valid;
    logic [LEN_W-1:0]      len;
    logic [KEY_W-1:0]      key;
    logic [VALUE_WIDTH-1:0] val;
  } lpht_slot_t;

  typedef struct packed {
    logic         ready;
    logic         clr_step;
    logic         load_work_req;
    logic         load_work_tmp;
    logic         hash_step;
    logic         probe_start;
    logic         main_rd;
    logic         probe_next;
    logic         write_slot;
    logic         count_up;
    logic         grow_start;
    logic         copy_rd;
    logic         copy_wr;
    logic         grow_double;
    logic         tmp_rd;
    logic         gi_inc;
    logic         set_res;
    logic         res_take_val;
    logic         out_load;
    lpht_status_t res_st;
  } lpht_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic clr_done;
    logic op_set;
    logic val_null;
    logic grow_need;
    logic hash_done;
    logic slot_valid;
    logic key_match;
    logic last_probe;
    logic gi_last;
    logic tmp_valid;
    logic out_free;
  } lpht_stat_t;

endpackage

### rtl/linear_probe_hash_table.sv
// Once an item is taken, its key is hashed one byte per step, then the probe loop reads and checks
// one slot at a time; a new item is taken only after the result is loaded into the output register.
// A set with a null value answers with the null status without hashing or probing. A set that
// doubles the table first copies the old table to a second store, then re-inserts each held entry.
// Reset: synchronous; a clearing pass sweeps every slot of the slot RAM before items are taken.
// Top level of the linear probing hash table.
module linear_probe_hash_table (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [103:0] s_tdata,  // key[63:0], key_len[67:64], value[99:68], zero fill
  input  logic         s_tuser,  // opcode
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [47:0]  m_tdata,  // value_out[31:0], entry_count[42:32], zero fill
  output logic [1:0]   m_tuser   // status
);
  import lpht_pkg::*;

  lpht_cmd_t  cmd;
  lpht_stat_t st;

  assign s_tready = cmd.ready;

  lpht_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .st  (st),
    .cmd (cmd)
  );

  lpht_dpath u_dpath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .st       (st),
    .s_tvalid (s_tvalid),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

### rtl/lpht_ram.sv
// Generic simple dual port RAM with registered read.
module lpht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/lpht_ctrl.sv
// Controller state machine of the hash table.
module lpht_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  lpht_pkg::lpht_stat_t st,
  output lpht_pkg::lpht_cmd_t  cmd
);
  import lpht_pkg::*;

  lpht_state_t state, state_next;
  logic        rehash, rehash_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_CLEAR;
      rehash <= 1'b0;
    end else begin
      state  <= state_next;
      rehash <= rehash_next;
    end
  end

  // next state
  always_comb begin
    state_next  = state;
    rehash_next = rehash;
    case (state)
      S_CLEAR: if (st.clr_done) state_next = S_IDLE;
      S_IDLE:  if (st.in_valid) state_next = S_START;
      S_START: begin
        if (st.op_set && st.val_null) begin
          state_next = S_RESP;
        end else if (st.op_set && st.grow_need) begin
          state_next = S_COPY_RD;
        end else begin
          state_next = S_HASH;
        end
      end
      S_HASH: if (st.hash_done) state_next = S_PRD;
      S_PRD:  state_next = S_PCHK;
      S_PCHK: begin
        if (st.slot_valid && !st.key_match && !st.last_probe) begin
          state_next = S_PRD;
        end else if (!rehash) begin
          state_next = S_RESP;
        end else if (st.gi_last) begin
          state_next  = S_HASH;
          rehash_next = 1'b0;
        end else begin
          state_next = S_TMP_RD;
        end
      end
      S_RESP: if (st.out_free) state_next = S_IDLE;
      S_COPY_RD: state_next = S_COPY_WR;
      S_COPY_WR: begin
        if (st.gi_last) begin
          state_next  = S_TMP_RD;
          rehash_next = 1'b1;
        end else begin
          state_next = S_COPY_RD;
        end
      end
      S_TMP_RD: state_next = S_TMP_CHK;
      S_TMP_CHK: begin
        if (st.tmp_valid) begin
          state_next = S_HASH;
        end else if (st.gi_last) begin
          state_next  = S_HASH;
          rehash_next = 1'b0;
        end else begin
          state_next = S_TMP_RD;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  // command outputs
  always_comb begin
    cmd        = '0;
    cmd.res_st = ST_OK;
    case (state)
      S_CLEAR: cmd.clr_step = 1'b1;
      S_IDLE:  cmd.ready = 1'b1;
      S_START: begin
        if (st.op_set && st.val_null) begin
          cmd.set_res = 1'b1;
          cmd.res_st  = ST_NULL;
        end else if (st.op_set && st.grow_need) begin
          cmd.grow_start = 1'b1;
        end else begin
          cmd.load_work_req = 1'b1;
        end
      end
      S_HASH: begin
        if (st.hash_done) cmd.probe_start = 1'b1;
        else              cmd.hash_step   = 1'b1;
      end
      S_PRD: cmd.main_rd = 1'b1;
      S_PCHK: begin
        if (st.slot_valid && !st.key_match && !st.last_probe) begin
          cmd.probe_next = 1'b1;
        end else if (rehash) begin
          // re-insert into an empty slot, then move to the next old entry or, after the last, the request
          cmd.write_slot = !st.slot_valid;
          if (st.gi_last) cmd.load_work_req = 1'b1;
          else            cmd.gi_inc        = 1'b1;
        end else if (!st.op_set) begin
          cmd.set_res = 1'b1;
          if (st.slot_valid && st.key_match) begin
            cmd.res_st       = ST_OK;
            cmd.res_take_val = 1'b1;
          end else begin
            cmd.res_st = ST_MISS;
          end
        end else begin
          cmd.set_res = 1'b1;
          if (!st.slot_valid) begin
            cmd.write_slot = 1'b1;
            cmd.count_up   = 1'b1;
            cmd.res_st     = ST_OK;
          end else if (st.key_match) begin
            cmd.write_slot = 1'b1;
            cmd.res_st     = ST_OK;
          end else begin
            cmd.res_st = ST_FULL;
          end
        end
      end
      S_RESP: cmd.out_load = st.out_free;
      S_COPY_RD: cmd.copy_rd = 1'b1;
      S_COPY_WR: begin
        cmd.copy_wr = 1'b1;
        if (st.gi_last) cmd.grow_double = 1'b1;
        else            cmd.gi_inc      = 1'b1;
      end
      S_TMP_RD: cmd.tmp_rd = 1'b1;
      S_TMP_CHK: begin
        if (st.tmp_valid)    cmd.load_work_tmp = 1'b1;
        else if (st.gi_last) cmd.load_work_req = 1'b1;
        else                 cmd.gi_inc        = 1'b1;
      end
      default: cmd = '0;
    endcase
  end

endmodule

### rtl/lpht_dpath.sv
// Datapath of the hash table: request, hash, probe, slot stores and output.
module lpht_dpath (
  input  logic                 clk,
  input  logic                 rst,
  input  lpht_pkg::lpht_cmd_t  cmd,
  output lpht_pkg::lpht_stat_t st,
  input  logic                 s_tvalid,
  input  logic [103:0]         s_tdata,
  input  logic                 s_tuser,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [47:0]          m_tdata,
  output logic [1:0]           m_tuser
);
  import lpht_pkg::*;

  // request registers
  logic                   r_op;
  logic [KEY_W-1:0]       r_key;
  logic [LEN_W-1:0]       r_len;
  logic [VALUE_WIDTH-1:0] r_val;

  // work registers
  logic [KEY_W-1:0]       w_key;
  logic [LEN_W-1:0]       w_len;
  logic [VALUE_WIDTH-1:0] w_val;
  logic [ADDR_W-1:0]      h;
  logic [LEN_W-1:0]       bcnt;
  logic [ADDR_W-1:0]      idx;
  logic [CNT_W-1:0]       n;
  logic [CNT_W-1:0]       cap;
  logic [CNT_W-1:0]       held;
  logic [CNT_W-1:0]       gi;
  logic [CNT_W-1:0]       old_cap;
  logic [ADDR_W-1:0]      clr_idx;
  lpht_status_t           res_st;
  logic [VALUE_WIDTH-1:0] res_val;

  logic [LEN_W-1:0]       in_len;
  logic [KEY_W-1:0]       in_key;
  logic [ADDR_W-1:0]      cap_mask;
  logic [7:0]             hbyte;

  lpht_slot_t main_wdata, main_rdata, tmp_rdata;
  logic       main_we, main_re;
  logic [ADDR_W-1:0] main_waddr, main_raddr;

  // saturate length and clear bytes beyond it
  always_comb begin
    in_len = (s_tdata[67:64] > LEN_W'(KEY_BYTES)) ? LEN_W'(KEY_BYTES) : s_tdata[67:64];
    for (int b = 0; b < 8; b++) begin
      in_key[b*8 +: 8] = (LEN_W'(b) < in_len) ? s_tdata[b*8 +: 8] : 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ready && s_tvalid) begin
      r_op  <= s_tuser;
      r_key <= in_key;
      r_len <= in_len;
      r_val <= s_tdata[68 +: VALUE_WIDTH];
    end
  end

  assign cap_mask = ADDR_W'(cap - 1'b1);
  assign hbyte    = w_key[bcnt[2:0]*8 +: 8];

  // hash and probe; only the low address bits of the hash are kept
  always_ff @(posedge clk) begin
    if (cmd.load_work_req) begin
      w_key <= r_key;
      w_len <= r_len;
      w_val <= r_val;
    end else if (cmd.load_work_tmp) begin
      w_key <= tmp_rdata.key;
      w_len <= tmp_rdata.len;
      w_val <= tmp_rdata.val;
    end
    if (cmd.load_work_req || cmd.load_work_tmp) begin
      h    <= HASH_BASIS[ADDR_W-1:0];
      bcnt <= '0;
    end else if (cmd.hash_step) begin
      h    <= ADDR_W'((h ^ ADDR_W'(hbyte)) * HASH_MULT[ADDR_W-1:0]);
      bcnt <= bcnt + 1'b1;
    end
    if (cmd.probe_start) begin
      idx <= h & cap_mask;
      n   <= '0;
    end else if (cmd.probe_next) begin
      idx <= (idx + 1'b1) & cap_mask;
      n   <= n + 1'b1;
    end
    if (cmd.grow_start) begin
      old_cap <= cap;
    end
    if (cmd.set_res) begin
      res_st  <= cmd.res_st;
      res_val <= cmd.res_take_val ? main_rdata.val : '0;
    end
  end

  // control counters
  always_ff @(posedge clk) begin
    if (rst) begin
      cap     <= CNT_W'(START_CAPACITY < MAX_CAPACITY ? START_CAPACITY : MAX_CAPACITY);
      held    <= '0;
      clr_idx <= '0;
      gi      <= '0;
    end else begin
      if (cmd.clr_step)    clr_idx <= clr_idx + 1'b1;
      if (cmd.count_up)    held <= held + 1'b1;
      if (cmd.grow_double) cap <= {cap[CNT_W-2:0], 1'b0};
      if (cmd.grow_start || cmd.grow_double) gi <= '0;
      else if (cmd.gi_inc)                   gi <= gi + 1'b1;
    end
  end

  // main slot store write and read selection
  always_comb begin
    main_we    = cmd.clr_step || cmd.copy_wr || cmd.write_slot;
    main_waddr = cmd.clr_step ? clr_idx : (cmd.copy_wr ? gi[ADDR_W-1:0] : idx);
    main_wdata = '0;
    if (cmd.write_slot) begin
      main_wdata.valid = 1'b1;
      main_wdata.len   = w_len;
      main_wdata.key   = w_key;
      main_wdata.val   = w_val;
    end
    main_re    = cmd.main_rd || cmd.copy_rd;
    main_raddr = cmd.copy_rd ? gi[ADDR_W-1:0] : idx;
  end

  lpht_ram #(.WIDTH($bits(lpht_slot_t)), .DEPTH(MAX_CAPACITY)) u_main (
    .clk   (clk),
    .we    (main_we),
    .waddr (main_waddr),
    .wdata (main_wdata),
    .re    (main_re),
    .raddr (main_raddr),
    .rdata (main_rdata)
  );

  // copy of the old table during growth
  lpht_ram #(.WIDTH($bits(lpht_slot_t)), .DEPTH(MAX_CAPACITY)) u_tmp (
    .clk   (clk),
    .we    (cmd.copy_wr),
    .waddr (gi[ADDR_W-1:0]),
    .wdata (main_rdata),
    .re    (cmd.tmp_rd),
    .raddr (gi[ADDR_W-1:0]),
    .rdata (tmp_rdata)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tuser <= res_st;
      m_tdata <= {5'd0, held, res_val};
    end
  end

  // status to the controller
  always_comb begin
    st.in_valid   = s_tvalid;
    st.clr_done   = (clr_idx == ADDR_W'(MAX_CAPACITY - 1));
    st.op_set     = r_op;
    st.val_null   = (r_val == '0);
    st.grow_need  = ({held, 1'b0} >= {1'b0, cap}) &&
                    ({cap, 1'b0} <= (CNT_W+1)'(MAX_CAPACITY));
    st.hash_done  = (bcnt == w_len);
    st.slot_valid = main_rdata.valid;
    st.key_match  = (main_rdata.len == w_len) && (main_rdata.key == w_key);
    st.last_probe = (n == cap - 1'b1);
    st.gi_last    = (gi == old_cap - 1'b1);
    st.tmp_valid  = tmp_rdata.valid;
    st.out_free   = !m_tvalid || m_tready;
  end

endmodule

### rtl/lpht_checker.sv
// Port checker for the hash table, bound to the top level.
`include "linear_probe_hash_table_assert.svh"

module lpht_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata,
  input logic [1:0]  m_tuser
);
  import lpht_pkg::*;

  // a stalled result holds
  `LPHT_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")
  // one item in work at a time
  `LPHT_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready, "second item taken while busy")
  // value is zero on any status other than OK
  `LPHT_ASSERT_ALWAYS(a_val_zero, !m_tvalid || m_tuser == ST_OK || m_tdata[31:0] == 32'd0, "value on failed item")
  // count never exceeds the largest table
  `LPHT_ASSERT_ALWAYS(a_count_max, !m_tvalid || m_tdata[42:32] <= 11'(MAX_CAPACITY), "count too high")

endmodule

bind linear_probe_hash_table lpht_checker u_chk (.*);
